>>> rtl/pmecs_pkg.sv
// ----------------------------------------------------------------------------
// pmecs_pkg
// Shared constants, types and codes for the charge spreading block.
// ----------------------------------------------------------------------------
package pmecs_pkg;

  // grid geometry
  localparam int GRID_MAX     = 32;
  localparam int SPLINE_ORDER = 5;
  localparam int IDX_W        = $clog2(GRID_MAX);
  localparam int ADDR_W       = 3 * IDX_W;
  localparam int DEPTH        = GRID_MAX * GRID_MAX * GRID_MAX;
  localparam int SIZE_W       = 6;
  localparam int CNT_W        = $clog2(SPLINE_ORDER);

  // number formats
  localparam int FRAC_BITS = 24;
  localparam int CHARGE_W  = 32;
  localparam int VAL_W     = 48;
  localparam int KIND_W    = 2;

  // reciprocal of three for the final divide by 24
  localparam int RECIP3_SHIFT = 30;
  localparam logic [29:0] RECIP3 = 30'd357913942;

  localparam logic [CNT_W-1:0] LAST_PT = CNT_W'(SPLINE_ORDER - 1);

  typedef logic [FRAC_BITS-1:0]    weight_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [SIZE_W-1:0]       size_t;
  typedef logic signed [VAL_W-1:0] grid_val_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_DEPOSIT = 2'd0,
    KIND_CLEAR   = 2'd1,
    KIND_READ    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WEIGHTS,
    ST_SPREAD,
    ST_DRAIN,
    ST_READ,
    ST_RESULT
  } state_t;

  typedef enum logic [3:0] {
    STEP_SCALE,
    STEP_P2,
    STEP_P3,
    STEP_P4,
    STEP_R2,
    STEP_R3,
    STEP_R4,
    STEP_NUM,
    STEP_W0,
    STEP_W1,
    STEP_W2,
    STEP_W3,
    STEP_W4
  } axis_step_t;

  // grid size actually used on one axis
  function automatic size_t eff_size(size_t v);
    size_t r;
    r = v;
    if (v < SIZE_W'(SPLINE_ORDER)) r = SIZE_W'(SPLINE_ORDER);
    else if (v > SIZE_W'(GRID_MAX)) r = SIZE_W'(GRID_MAX);
    return r;
  endfunction

endpackage

>>> rtl/pmecs_if.sv
// ----------------------------------------------------------------------------
// pmecs_if
// Request and response channels of the charge spreading block.
// ----------------------------------------------------------------------------
interface pmecs_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [pmecs_pkg::KIND_W-1:0]         kind;
  logic signed [pmecs_pkg::CHARGE_W-1:0] charge;
  logic [pmecs_pkg::FRAC_BITS-1:0]      frac_x;
  logic [pmecs_pkg::FRAC_BITS-1:0]      frac_y;
  logic [pmecs_pkg::FRAC_BITS-1:0]      frac_z;
  logic [pmecs_pkg::IDX_W-1:0]          read_x;
  logic [pmecs_pkg::IDX_W-1:0]          read_y;
  logic [pmecs_pkg::IDX_W-1:0]          read_z;

  modport source (output valid, kind, charge, frac_x, frac_y, frac_z,
                  read_x, read_y, read_z, input ready);
  modport sink (input valid, kind, charge, frac_x, frac_y, frac_z,
                read_x, read_y, read_z, output ready);
endinterface

interface pmecs_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [pmecs_pkg::VAL_W-1:0] grid_value;
  logic                              overflow_seen;

  modport source (output valid, grid_value, overflow_seen, input ready);
  modport sink (input valid, grid_value, overflow_seen, output ready);
endinterface

>>> rtl/pmecs_axis_weights.sv
// ----------------------------------------------------------------------------
// pmecs_axis_weights
// B-spline weights and wrapped indices for one axis, one shared multiplier.
// ----------------------------------------------------------------------------
module pmecs_axis_weights (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [pmecs_pkg::FRAC_BITS-1:0] frac,
  input  pmecs_pkg::size_t                n,
  output logic                            done,
  output pmecs_pkg::weight_t              w   [pmecs_pkg::SPLINE_ORDER],
  output pmecs_pkg::idx_t                 idx [pmecs_pkg::SPLINE_ORDER]
);

  pmecs_pkg::axis_step_t           step;
  logic                            busy;
  logic [pmecs_pkg::FRAC_BITS-1:0] frac_r;
  pmecs_pkg::size_t                n_r;
  logic [23:0]                     t;
  pmecs_pkg::idx_t                 f;
  logic [23:0]                     p2, p3, p4;
  logic [24:0]                     r, r2, r3, r4;
  logic [27:0]                     x [pmecs_pkg::SPLINE_ORDER];
  logic [27:0]                     mul_a;
  logic [29:0]                     mul_b;
  logic [57:0]                     prod;
  logic signed [31:0]              num [pmecs_pkg::SPLINE_ORDER];
  logic [27:0]                     x_next [pmecs_pkg::SPLINE_ORDER];
  pmecs_pkg::idx_t                 idx_next [pmecs_pkg::SPLINE_ORDER];

  assign r = 25'h1000000 - {1'b0, t};

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step)
      pmecs_pkg::STEP_SCALE: begin mul_a = 28'(frac_r); mul_b = 30'(n_r); end
      pmecs_pkg::STEP_P2:    begin mul_a = 28'(t);      mul_b = 30'(t);   end
      pmecs_pkg::STEP_P3:    begin mul_a = 28'(p2);     mul_b = 30'(t);   end
      pmecs_pkg::STEP_P4:    begin mul_a = 28'(p3);     mul_b = 30'(t);   end
      pmecs_pkg::STEP_R2:    begin mul_a = 28'(r);      mul_b = 30'(r);   end
      pmecs_pkg::STEP_R3:    begin mul_a = 28'(r2);     mul_b = 30'(r);   end
      pmecs_pkg::STEP_R4:    begin mul_a = 28'(r3);     mul_b = 30'(r);   end
      pmecs_pkg::STEP_W0:    begin mul_a = x[0]; mul_b = pmecs_pkg::RECIP3; end
      pmecs_pkg::STEP_W1:    begin mul_a = x[1]; mul_b = pmecs_pkg::RECIP3; end
      pmecs_pkg::STEP_W2:    begin mul_a = x[2]; mul_b = pmecs_pkg::RECIP3; end
      pmecs_pkg::STEP_W3:    begin mul_a = x[3]; mul_b = pmecs_pkg::RECIP3; end
      pmecs_pkg::STEP_W4:    begin mul_a = x[4]; mul_b = pmecs_pkg::RECIP3; end
      default:               begin mul_a = '0;   mul_b = '0;                end
    endcase
  end

  assign prod = 58'(mul_a) * 58'(mul_b);

  // spline numerators scaled by 24, then (num + 12) / 8 ahead of the divide by 3
  always_comb begin
    logic signed [31:0] st, s2, s3, s4, one;
    logic signed [31:0] nz;
    logic signed [31:0] ofs;
    logic signed [7:0]  img;
    st  = $signed({8'd0, t});
    s2  = $signed({8'd0, p2});
    s3  = $signed({8'd0, p3});
    s4  = $signed({8'd0, p4});
    one = 32'sh1000000;
    num[0] = $signed({7'd0, r4});
    num[1] = -32'sd4 * s4 + 32'sd12 * s3 - 32'sd6 * s2 - 32'sd12 * st + 32'sd11 * one;
    num[2] = 32'sd6 * s4 - 32'sd12 * s3 - 32'sd6 * s2 + 32'sd12 * st + 32'sd11 * one;
    num[3] = -32'sd4 * s4 + 32'sd4 * s3 + 32'sd6 * s2 + 32'sd4 * st + one;
    num[4] = s4;
    for (int a = 0; a < pmecs_pkg::SPLINE_ORDER; a++) begin
      nz  = num[a][31] ? 32'sd0 : num[a];
      ofs = nz + 32'sd12;
      x_next[a] = ofs[30:3];
      img = $signed({3'd0, f}) + 8'(a) - 8'(pmecs_pkg::SPLINE_ORDER - 1);
      if (img < 0) img = img + $signed({2'd0, n_r});
      idx_next[a] = pmecs_pkg::idx_t'(img);
    end
  end

  // step sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= pmecs_pkg::STEP_SCALE;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= pmecs_pkg::STEP_SCALE;
    end else if (busy) begin
      if (step == pmecs_pkg::STEP_W4) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        step <= pmecs_pkg::axis_step_t'(step + 4'd1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      frac_r <= frac;
      n_r    <= n;
    end
    if (busy) begin
      unique case (step)
        pmecs_pkg::STEP_SCALE: begin
          t <= prod[23:0];
          f <= prod[24 +: pmecs_pkg::IDX_W];
        end
        pmecs_pkg::STEP_P2: p2 <= prod[47:24];
        pmecs_pkg::STEP_P3: p3 <= prod[47:24];
        pmecs_pkg::STEP_P4: p4 <= prod[47:24];
        pmecs_pkg::STEP_R2: r2 <= prod[48:24];
        pmecs_pkg::STEP_R3: r3 <= prod[48:24];
        pmecs_pkg::STEP_R4: r4 <= prod[48:24];
        pmecs_pkg::STEP_NUM: begin
          x   <= x_next;
          idx <= idx_next;
        end
        pmecs_pkg::STEP_W0: w[0] <= prod[pmecs_pkg::RECIP3_SHIFT +: pmecs_pkg::FRAC_BITS];
        pmecs_pkg::STEP_W1: w[1] <= prod[pmecs_pkg::RECIP3_SHIFT +: pmecs_pkg::FRAC_BITS];
        pmecs_pkg::STEP_W2: w[2] <= prod[pmecs_pkg::RECIP3_SHIFT +: pmecs_pkg::FRAC_BITS];
        pmecs_pkg::STEP_W3: w[3] <= prod[pmecs_pkg::RECIP3_SHIFT +: pmecs_pkg::FRAC_BITS];
        pmecs_pkg::STEP_W4: w[4] <= prod[pmecs_pkg::RECIP3_SHIFT +: pmecs_pkg::FRAC_BITS];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/pmecs_grid_ram.sv
// ----------------------------------------------------------------------------
// pmecs_grid_ram
// Charge grid storage, one write and one registered read port.
// ----------------------------------------------------------------------------
module pmecs_grid_ram (
  input  logic                 clk,
  input  logic                 wr_en,
  input  pmecs_pkg::addr_t     wr_addr,
  input  pmecs_pkg::grid_val_t wr_data,
  input  logic                 rd_en,
  input  pmecs_pkg::addr_t     rd_addr,
  output pmecs_pkg::grid_val_t rd_data
);

  pmecs_pkg::grid_val_t mem [pmecs_pkg::DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/pme_charge_spreading.sv
// ----------------------------------------------------------------------------
// pme_charge_spreading
// Order-5 B-spline charge assignment onto a periodic 3-D accumulation grid.
// ----------------------------------------------------------------------------
// A deposit item runs the three per-axis weight units (one shared
// multiplier each, working in parallel), then 125 read-modify-write
// updates, one per cycle through the grid memory, and then the update
// pipeline drains before the next item is taken. A read item reads the
// grid memory and returns its value through the result register. A clear
// item, and reset itself, sweep all 32768 grid entries to zero one per
// cycle, and the block takes no item until that sweep ends;
// configuration writes are taken at any time.
module pme_charge_spreading (
  input  logic                 clk,
  input  logic                 rst,
  pmecs_req_if.sink            req,
  pmecs_rsp_if.source          rsp,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  pmecs_pkg::state_t    state, state_next;
  pmecs_pkg::size_t     size_x, size_y, size_z;
  pmecs_pkg::size_t     nx, ny, nz;
  logic signed [pmecs_pkg::CHARGE_W-1:0] q;
  logic [pmecs_pkg::CNT_W-1:0] a_cnt, b_cnt, c_cnt;
  logic                 req_acc, spread_last;
  logic                 start_w, x_done, y_done, z_done;
  pmecs_pkg::weight_t   wx [pmecs_pkg::SPLINE_ORDER];
  pmecs_pkg::weight_t   wy [pmecs_pkg::SPLINE_ORDER];
  pmecs_pkg::weight_t   wz [pmecs_pkg::SPLINE_ORDER];
  pmecs_pkg::idx_t      ix [pmecs_pkg::SPLINE_ORDER];
  pmecs_pkg::idx_t      iy [pmecs_pkg::SPLINE_ORDER];
  pmecs_pkg::idx_t      iz [pmecs_pkg::SPLINE_ORDER];
  logic                 s1_v, s2_v, s3_v;
  pmecs_pkg::weight_t   s1_wxy, s1_wz, s2_w;
  pmecs_pkg::addr_t     s1_addr, s2_addr, s3_addr;
  pmecs_pkg::grid_val_t s3_add;
  logic [47:0]          wxy_prod, w_prod;
  logic signed [56:0]   q_prod;
  logic signed [48:0]   sum;
  pmecs_pkg::grid_val_t sat;
  logic                 sat_hit;
  pmecs_pkg::addr_t     clr_addr;
  logic                 ovf;
  pmecs_pkg::addr_t     rd_pt;
  logic                 rd_ok;
  logic                 mem_wr_en, mem_rd_en;
  pmecs_pkg::addr_t     mem_wr_addr, mem_rd_addr;
  pmecs_pkg::grid_val_t mem_wr_data, mem_rd_data;
  logic                 rsp_valid, rsp_ovf;
  pmecs_pkg::grid_val_t rsp_value;
  logic                 cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= pmecs_pkg::SIZE_W'(pmecs_pkg::GRID_MAX);
      size_y <= pmecs_pkg::SIZE_W'(pmecs_pkg::GRID_MAX);
      size_z <= pmecs_pkg::SIZE_W'(pmecs_pkg::GRID_MAX);
    end else if (cfg_wr) begin
      priority case (paddr[3:2])
        pmecs_pkg::REG_SIZE_X: size_x <= pwdata[pmecs_pkg::SIZE_W-1:0];
        pmecs_pkg::REG_SIZE_Y: size_y <= pwdata[pmecs_pkg::SIZE_W-1:0];
        pmecs_pkg::REG_SIZE_Z: size_z <= pwdata[pmecs_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority case (paddr[3:2])
      pmecs_pkg::REG_SIZE_X: prdata = 32'(size_x);
      pmecs_pkg::REG_SIZE_Y: prdata = 32'(size_y);
      pmecs_pkg::REG_SIZE_Z: prdata = 32'(size_z);
      default:               prdata = '0;
    endcase
  end

  assign nx = pmecs_pkg::eff_size(size_x);
  assign ny = pmecs_pkg::eff_size(size_y);
  assign nz = pmecs_pkg::eff_size(size_z);

  // per-axis weight units
  pmecs_axis_weights u_axis_x (
    .clk(clk), .rst(rst), .start(start_w), .frac(req.frac_x), .n(nx),
    .done(x_done), .w(wx), .idx(ix)
  );
  pmecs_axis_weights u_axis_y (
    .clk(clk), .rst(rst), .start(start_w), .frac(req.frac_y), .n(ny),
    .done(y_done), .w(wy), .idx(iy)
  );
  pmecs_axis_weights u_axis_z (
    .clk(clk), .rst(rst), .start(start_w), .frac(req.frac_z), .n(nz),
    .done(z_done), .w(wz), .idx(iz)
  );

  assign req.ready   = (state == pmecs_pkg::ST_IDLE);
  assign req_acc     = req.valid && req.ready;
  assign start_w     = req_acc && (req.kind == pmecs_pkg::KIND_DEPOSIT);
  assign spread_last = (a_cnt == pmecs_pkg::LAST_PT) && (b_cnt == pmecs_pkg::LAST_PT) &&
                       (c_cnt == pmecs_pkg::LAST_PT);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pmecs_pkg::ST_CLEAR:   if (&clr_addr) state_next = pmecs_pkg::ST_IDLE;
      pmecs_pkg::ST_IDLE: begin
        if (req_acc) begin
          priority if (req.kind == pmecs_pkg::KIND_DEPOSIT) state_next = pmecs_pkg::ST_WEIGHTS;
          else if (req.kind == pmecs_pkg::KIND_CLEAR) state_next = pmecs_pkg::ST_CLEAR;
          else if (req.kind == pmecs_pkg::KIND_READ) state_next = pmecs_pkg::ST_READ;
          else state_next = pmecs_pkg::ST_IDLE;
        end
      end
      pmecs_pkg::ST_WEIGHTS: if (x_done) state_next = pmecs_pkg::ST_SPREAD;
      pmecs_pkg::ST_SPREAD:  if (spread_last) state_next = pmecs_pkg::ST_DRAIN;
      pmecs_pkg::ST_DRAIN:   if (!(s1_v || s2_v || s3_v)) state_next = pmecs_pkg::ST_IDLE;
      pmecs_pkg::ST_READ:    state_next = pmecs_pkg::ST_RESULT;
      pmecs_pkg::ST_RESULT:  if (!rsp_valid || rsp.ready) state_next = pmecs_pkg::ST_IDLE;
      default:               state_next = pmecs_pkg::ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    mem_wr_en   = s3_v;
    mem_wr_addr = s3_addr;
    mem_wr_data = sat;
    mem_rd_en   = s2_v;
    mem_rd_addr = s2_addr;
    unique case (state)
      pmecs_pkg::ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_addr;
        mem_wr_data = '0;
      end
      pmecs_pkg::ST_READ: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = rd_pt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= pmecs_pkg::ST_CLEAR;
    else     state <= state_next;
  end

  // clear sweep
  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (state == pmecs_pkg::ST_CLEAR) clr_addr <= clr_addr + 1'b1;
  end

  // item capture and point counters
  always_ff @(posedge clk) begin
    if (req_acc) begin
      q     <= req.charge;
      rd_pt <= {req.read_x, req.read_y, req.read_z};
      rd_ok <= ({1'b0, req.read_x} < nx) && ({1'b0, req.read_y} < ny) &&
               ({1'b0, req.read_z} < nz);
      a_cnt <= '0;
      b_cnt <= '0;
      c_cnt <= '0;
    end else if (state == pmecs_pkg::ST_SPREAD) begin
      if (c_cnt == pmecs_pkg::LAST_PT) begin
        c_cnt <= '0;
        if (b_cnt == pmecs_pkg::LAST_PT) begin
          b_cnt <= '0;
          a_cnt <= a_cnt + 1'b1;
        end else begin
          b_cnt <= b_cnt + 1'b1;
        end
      end else begin
        c_cnt <= c_cnt + 1'b1;
      end
    end
  end

  // accumulation pipeline: weight products, charge scaling, read, add, write
  assign wxy_prod = 48'(wx[a_cnt]) * 48'(wy[b_cnt]);
  assign w_prod   = 48'(s1_wxy) * 48'(s1_wz);
  assign q_prod   = 57'(q) * $signed({33'd0, s2_w});
  assign sum      = {mem_rd_data[47], mem_rd_data} + {s3_add[47], s3_add};
  assign sat_hit  = sum[48] != sum[47];
  assign sat      = !sat_hit ? sum[47:0] : (sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}});

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      s1_v <= (state == pmecs_pkg::ST_SPREAD);
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_wxy  <= wxy_prod[47:24];
    s1_wz   <= wz[c_cnt];
    s1_addr <= {ix[a_cnt], iy[b_cnt], iz[c_cnt]};
    s2_w    <= w_prod[47:24];
    s2_addr <= s1_addr;
    s3_add  <= q_prod[55:8];
    s3_addr <= s2_addr;
  end

  // sticky overflow flag
  always_ff @(posedge clk) begin
    if (rst) ovf <= 1'b0;
    else if (req_acc && (req.kind == pmecs_pkg::KIND_CLEAR)) ovf <= 1'b0;
    else if (s3_v && sat_hit) ovf <= 1'b1;
  end

  pmecs_grid_ram u_grid (
    .clk(clk), .wr_en(mem_wr_en), .wr_addr(mem_wr_addr), .wr_data(mem_wr_data),
    .rd_en(mem_rd_en), .rd_addr(mem_rd_addr), .rd_data(mem_rd_data)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == pmecs_pkg::ST_RESULT && (!rsp_valid || rsp.ready)) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == pmecs_pkg::ST_RESULT && (!rsp_valid || rsp.ready)) begin
      rsp_value <= rd_ok ? mem_rd_data : '0;
      rsp_ovf   <= ovf;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.grid_value    = rsp_value;
  assign rsp.overflow_seen = rsp_ovf;

`ifndef ASSERT_OFF
  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !(s1_v || s2_v || s3_v))
    else $error("item taken while grid updates are in flight");

  a_axes_lockstep: assert property (@(posedge clk) disable iff (rst)
    (x_done == y_done) && (y_done == z_done))
    else $error("axis weight units out of step");

  a_flag_clear: assert property (@(posedge clk) disable iff (rst)
    $fell(ovf) |-> (state == pmecs_pkg::ST_CLEAR))
    else $error("overflow flag dropped outside a clear");

  a_result_path: assert property (@(posedge clk) disable iff (rst)
    (state == pmecs_pkg::ST_RESULT) |->
      ($past(state) == pmecs_pkg::ST_READ || $past(state) == pmecs_pkg::ST_RESULT))
    else $error("result state entered without a grid read");
`endif

endmodule

>>> tb/pme_charge_spreading_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pme_charge_spreading_tb
// Drives deposit, clear and read items through the charge spreading block
// under several grid sizes, with random gaps and stalls on both channels.
// A shadow charge grid predicts every read result, and each result is
// compared field by field.
// ----------------------------------------------------------------------------
module pme_charge_spreading_tb;

  localparam logic [pmecs_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int HOLD_CYCLES  = 3000;
  localparam int SETTLE_CYCLES = 300;
  localparam int PHASE_ITEMS  = 280;

  typedef struct {
    logic [pmecs_pkg::KIND_W-1:0]          kind;
    logic signed [pmecs_pkg::CHARGE_W-1:0] charge;
    logic [pmecs_pkg::FRAC_BITS-1:0]       fx, fy, fz;
    pmecs_pkg::idx_t                       rx, ry, rz;
  } pme_item_t;

  // shadow grid and the read results it predicts
  class charge_grid_model;
    longint               cells[pmecs_pkg::DEPTH];
    bit                   sat_flag;
    int                   sizes[3];
    pmecs_pkg::grid_val_t want_value[$];
    bit                   want_flag[$];
    int                   errors;

    function new();
      wipe();
      foreach (sizes[i]) sizes[i] = pmecs_pkg::GRID_MAX;
      errors = 0;
    endfunction

    function void wipe();
      foreach (cells[i]) cells[i] = 0;
      sat_flag = 0;
    endfunction

    function int eff(int axis);
      if (sizes[axis] < pmecs_pkg::SPLINE_ORDER) return pmecs_pkg::SPLINE_ORDER;
      if (sizes[axis] > pmecs_pkg::GRID_MAX) return pmecs_pkg::GRID_MAX;
      return sizes[axis];
    endfunction

    function int floor_cell(logic [pmecs_pkg::FRAC_BITS-1:0] frac, int axis);
      longint u;
      u = longint'(frac) * eff(axis);
      return int'(u >>> pmecs_pkg::FRAC_BITS);
    endfunction

    // spline weights in Q0.24 and wrapped indices along one axis
    function void spline(logic [pmecs_pkg::FRAC_BITS-1:0] frac, int n,
                         output longint w[5], output int idx[5]);
      longint u, f, t, p2, p3, p4, r, r2, r3, r4, img;
      longint num[5];
      u = longint'(frac) * n;
      f = u >>> pmecs_pkg::FRAC_BITS;
      t = u & 64'hFFFFFF;
      p2 = (t * t) >>> pmecs_pkg::FRAC_BITS;
      p3 = (p2 * t) >>> pmecs_pkg::FRAC_BITS;
      p4 = (p3 * t) >>> pmecs_pkg::FRAC_BITS;
      r = (64'd1 << pmecs_pkg::FRAC_BITS) - t;
      r2 = (r * r) >>> pmecs_pkg::FRAC_BITS;
      r3 = (r2 * r) >>> pmecs_pkg::FRAC_BITS;
      r4 = (r3 * r) >>> pmecs_pkg::FRAC_BITS;
      num[0] = r4;
      num[1] = -4*p4 + 12*p3 - 6*p2 - 12*t + 11*(64'd1 << pmecs_pkg::FRAC_BITS);
      num[2] = 6*p4 - 12*p3 - 6*p2 + 12*t + 11*(64'd1 << pmecs_pkg::FRAC_BITS);
      num[3] = -4*p4 + 4*p3 + 6*p2 + 4*t + (64'd1 << pmecs_pkg::FRAC_BITS);
      num[4] = p4;
      for (int a = 0; a < 5; a++) begin
        if (num[a] < 0) num[a] = 0;
        w[a] = (num[a] + 12) / 24;
        img = f + a - (pmecs_pkg::SPLINE_ORDER - 1);
        if (img < 0) img += n;
        if (img < 0) img = 0;
        if (img >= n) img = n - 1;
        idx[a] = int'(img);
      end
    endfunction

    function void spread(pme_item_t it);
      longint wx[5], wy[5], wz[5];
      int ix[5], iy[5], iz[5];
      longint wxy, w, add, s;
      int pos;
      spline(it.fx, eff(0), wx, ix);
      spline(it.fy, eff(1), wy, iy);
      spline(it.fz, eff(2), wz, iz);
      for (int a = 0; a < 5; a++)
        for (int b = 0; b < 5; b++) begin
          wxy = (wx[a] * wy[b]) >>> pmecs_pkg::FRAC_BITS;
          for (int c = 0; c < 5; c++) begin
            w = (wxy * wz[c]) >>> pmecs_pkg::FRAC_BITS;
            // arithmetic shift floors toward minus infinity
            add = (longint'(it.charge) * w) >>> 8;
            pos = (ix[a] * pmecs_pkg::GRID_MAX + iy[b]) * pmecs_pkg::GRID_MAX + iz[c];
            s = cells[pos] + add;
            if (s > (64'sd1 <<< 47) - 1) begin
              s = (64'sd1 <<< 47) - 1;
              sat_flag = 1;
            end
            if (s < -(64'sd1 <<< 47)) begin
              s = -(64'sd1 <<< 47);
              sat_flag = 1;
            end
            cells[pos] = s;
          end
        end
    endfunction

    // called once per accepted input item
    function void note_item(pme_item_t it);
      longint v;
      case (it.kind)
        pmecs_pkg::KIND_DEPOSIT: spread(it);
        pmecs_pkg::KIND_CLEAR:   wipe();
        pmecs_pkg::KIND_READ: begin
          v = 0;
          if (it.rx < eff(0) && it.ry < eff(1) && it.rz < eff(2))
            v = cells[(int'(it.rx) * pmecs_pkg::GRID_MAX + it.ry) * pmecs_pkg::GRID_MAX
                      + it.rz];
          want_value.push_back(pmecs_pkg::grid_val_t'(v));
          want_flag.push_back(sat_flag);
        end
        default: ;
      endcase
    endfunction

    // called once per accepted result item
    function void check_result(pmecs_pkg::grid_val_t value, logic flag);
      pmecs_pkg::grid_val_t ev;
      bit ef;
      if (want_value.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: value %0d flag %0b", value, flag);
        return;
      end
      ev = want_value.pop_front();
      ef = want_flag.pop_front();
      if (value !== ev || flag !== ef) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: value exp %0d got %0d, flag exp %0b got %0b",
                   ev, value, ef, flag);
      end
    endfunction

    function int waiting();
      return want_value.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  bit long_hold;

  pmecs_req_if req ();
  pmecs_rsp_if rsp ();

  charge_grid_model grid_model = new();

  pme_charge_spreading i_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req.sink),
    .rsp     (rsp.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // item monitors
  always @(posedge clk) begin
    pme_item_t it;
    if (!rst && req.valid && req.ready) begin
      it.kind = req.kind;
      it.charge = req.charge;
      it.fx = req.frac_x;
      it.fy = req.frac_y;
      it.fz = req.frac_z;
      it.rx = req.read_x;
      it.ry = req.read_y;
      it.rz = req.read_z;
      grid_model.note_item(it);
    end
    if (!rst && rsp.valid && rsp.ready)
      grid_model.check_result(rsp.grid_value, rsp.overflow_seen);
  end

  // result side: random stalls and one long hold-off
  initial begin
    int gap;
    rsp.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold) begin
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 0;
      end else if ($urandom_range(3) == 0) begin
        gap = ($urandom_range(15) == 0) ? $urandom_range(60, 20) : $urandom_range(4, 1);
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        rsp.ready <= 1'b1;
        repeat ($urandom_range(20, 1)) @(posedge clk);
      end
    end
  end

  task automatic send_item(pme_item_t it);
    req.kind   <= it.kind;
    req.charge <= it.charge;
    req.frac_x <= it.fx;
    req.frac_y <= it.fy;
    req.frac_z <= it.fz;
    req.read_x <= it.rx;
    req.read_y <= it.ry;
    req.read_z <= it.rz;
    req.valid  <= 1'b1;
    do @(posedge clk); while (!req.ready);
  endtask

  // random gap after an item, usually none
  task automatic sender_gap();
    int n;
    case ($urandom_range(9))
      0, 1, 2: n = $urandom_range(3, 1);
      3:       n = ($urandom_range(7) == 0) ? $urandom_range(80, 20) : $urandom_range(8, 1);
      default: n = 0;
    endcase
    if (n > 0) begin
      req.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    @(posedge clk);
    while (grid_model.waiting() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(pmecs_pkg::reg_idx_t r, int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(r) << 2;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    grid_model.sizes[r] = value;
  endtask

  function automatic pme_item_t make_item(logic [pmecs_pkg::KIND_W-1:0] kind,
                                          logic signed [pmecs_pkg::CHARGE_W-1:0] q,
                                          logic [pmecs_pkg::FRAC_BITS-1:0] fx, fy, fz,
                                          pmecs_pkg::idx_t rx, ry, rz);
    pme_item_t it;
    it.kind = kind;
    it.charge = q;
    it.fx = fx;
    it.fy = fy;
    it.fz = fz;
    it.rx = rx;
    it.ry = ry;
    it.rz = rz;
    return it;
  endfunction

  function automatic pme_item_t rand_item(logic [pmecs_pkg::KIND_W-1:0] kind);
    pme_item_t it;
    it = make_item(kind, $urandom, 24'($urandom), 24'($urandom), 24'($urandom),
                   pmecs_pkg::idx_t'($urandom), pmecs_pkg::idx_t'($urandom),
                   pmecs_pkg::idx_t'($urandom));
    // reads mostly land inside the grid in use
    if ($urandom_range(9) < 7) begin
      it.rx = pmecs_pkg::idx_t'($urandom_range(grid_model.eff(0) - 1));
      it.ry = pmecs_pkg::idx_t'($urandom_range(grid_model.eff(1) - 1));
      it.rz = pmecs_pkg::idx_t'($urandom_range(grid_model.eff(2) - 1));
    end
    return it;
  endfunction

  // a run of same-sign heavy deposits at one spot, then reads around it
  task automatic deposit_burst(output int sent);
    pme_item_t it;
    int len;
    bit neg;
    len = $urandom_range(20, 6);
    neg = $urandom_range(1);
    it = rand_item(pmecs_pkg::KIND_DEPOSIT);
    for (int i = 0; i < len; i++) begin
      it.charge = neg ? -$signed({1'b0, 31'($urandom_range(32'h7FFF_FFFF, 32'h4000_0000))})
                      : $urandom_range(32'h7FFF_FFFF, 32'h4000_0000);
      send_item(it);
      sender_gap();
    end
    it.kind = pmecs_pkg::KIND_READ;
    it.rx = pmecs_pkg::idx_t'(grid_model.floor_cell(it.fx, 0));
    it.ry = pmecs_pkg::idx_t'(grid_model.floor_cell(it.fy, 1));
    it.rz = pmecs_pkg::idx_t'(grid_model.floor_cell(it.fz, 2));
    send_item(it);
    it.rx = (it.rx == 0) ? pmecs_pkg::idx_t'(grid_model.eff(0) - 1) : it.rx - 1'b1;
    send_item(it);
    sent = len + 2;
  endtask

  task automatic random_phase(int count, bit mid_pause);
    int sent, n;
    int pct;
    sent = 0;
    while (sent < count) begin
      pct = $urandom_range(999);
      if (mid_pause && sent >= count / 2) begin
        wait_drained();
        mid_pause = 0;
      end
      if (pct < 4) begin
        send_item(rand_item(pmecs_pkg::KIND_CLEAR));
        sent++;
      end else if (pct < 60) begin
        deposit_burst(n);
        sent += n;
      end else if (pct < 80) begin
        send_item(rand_item(KIND_UNUSED));
        sent++;
      end else if (pct < 700) begin
        send_item(rand_item(pmecs_pkg::KIND_DEPOSIT));
        sent++;
      end else begin
        send_item(rand_item(pmecs_pkg::KIND_READ));
        sent++;
      end
      sender_gap();
    end
  endtask

  task automatic set_sizes(int sx, int sy, int sz);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    // a clear sweep may still be running
    while (!req.ready) @(posedge clk);
    cfg_write(pmecs_pkg::REG_SIZE_X, sx);
    cfg_write(pmecs_pkg::REG_SIZE_Y, sy);
    cfg_write(pmecs_pkg::REG_SIZE_Z, sz);
  endtask

  // limit
  initial begin
    #30_000_000;
    $display("Mismatches found");
    $finish;
  end

  // stimulus
  initial begin
    rst = 1'b1;
    long_hold = 0;
    {psel, penable, pwrite} = 3'b000;
    paddr = '0;
    pwdata = '0;
    req.valid = 1'b0;
    req.kind = pmecs_pkg::KIND_DEPOSIT;
    req.charge = '0;
    {req.frac_x, req.frac_y, req.frac_z} = '0;
    {req.read_x, req.read_y, req.read_z} = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, reads at the grid corners and edges, unused kind
    send_item(make_item(pmecs_pkg::KIND_DEPOSIT, 32'sh7FFF_FFFF, 24'h0, 24'h0, 24'h0,
                        0, 0, 0));
    send_item(make_item(pmecs_pkg::KIND_DEPOSIT, 32'sh8000_0000, 24'hFF_FFFF, 24'hFF_FFFF,
                        24'hFF_FFFF, 0, 0, 0));
    send_item(make_item(pmecs_pkg::KIND_DEPOSIT, 32'sh0001_0000, 24'h80_0000, 24'h00_0001,
                        24'hFF_FFFE, 0, 0, 0));
    send_item(make_item(pmecs_pkg::KIND_DEPOSIT, 32'sh0, 24'h55_5555, 24'hAA_AAAA,
                        24'h12_3456, 0, 0, 0));
    send_item(make_item(pmecs_pkg::KIND_DEPOSIT, -32'sd1, 24'h7F_FFFF, 24'h0, 24'h80_0000,
                        0, 0, 0));
    send_item(make_item(pmecs_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(pmecs_pkg::KIND_READ, 0, 0, 0, 0, 31, 31, 31));
    send_item(make_item(pmecs_pkg::KIND_READ, 0, 0, 0, 0, 28, 0, 31));
    send_item(make_item(KIND_UNUSED, 0, 0, 0, 0, 1, 1, 1));
    // saturation at one spot, then the sticky flag
    for (int i = 0; i < 12; i++)
      send_item(make_item(pmecs_pkg::KIND_DEPOSIT, 32'sh7FFF_FFFF, 24'h10_0000, 24'h10_0000,
                          24'h10_0000, 0, 0, 0));
    send_item(make_item(pmecs_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(pmecs_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(pmecs_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0));

    // smallest grid; receiver holds off while reads pile up
    set_sizes(5, 5, 5);
    long_hold = 1;
    for (int i = 0; i < 30; i++)
      send_item(rand_item(pmecs_pkg::KIND_READ));
    random_phase(PHASE_ITEMS, 0);

    set_sizes(7, 13, 32);
    random_phase(PHASE_ITEMS, 1);

    // sizes outside the legal range
    set_sizes(0, 63, 4);
    random_phase(PHASE_ITEMS, 0);

    set_sizes(32, 5, 17);
    random_phase(PHASE_ITEMS, 0);

    set_sizes(32, 32, 32);
    random_phase(PHASE_ITEMS, 0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (grid_model.errors == 0 && grid_model.waiting() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
